// ===== rtl/record_header_utf8_checker_macros.svh =====
// Assertion macros used by the record header checker's assertion module, rhu8_checker.
// Needs clk and rst_n in scope where a macro is used.
`ifndef RECORD_HEADER_UTF8_CHECKER_MACROS_SVH
`define RECORD_HEADER_UTF8_CHECKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RHU8_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RHU8_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rhu8_pkg.sv =====
// Types and constants for the record header / UTF-8 checker.
// No dependencies; used by every module of the checker and its testbench.
package rhu8_pkg;

    localparam int POS_W = 7;

    localparam int HEADER_BYTES   = 56;
    localparam int MAX_TEXT_BYTES = 64;

    localparam logic [POS_W-1:0] POS_MAX     = 7'd127;
    localparam logic [POS_W-1:0] POS_VERSION = 7'd1;
    localparam logic [POS_W-1:0] POS_MAGIC3  = 7'd3;
    localparam logic [POS_W-1:0] ID_FIRST    = 7'd4;
    localparam logic [POS_W-1:0] ID_LAST     = 7'd19;
    localparam logic [POS_W-1:0] HASH_FIRST  = 7'd20;
    localparam logic [POS_W-1:0] HASH_LAST   = 7'd51;
    localparam logic [POS_W-1:0] PAD_FIRST   = 7'd52;
    localparam logic [POS_W-1:0] PAD_LAST    = 7'd54;
    localparam logic [POS_W-1:0] POS_LEN     = 7'd55;
    localparam logic [POS_W-1:0] POS_TEXT    = 7'(HEADER_BYTES);

    localparam logic [7:0] VERSION_IN   = 8'd1;
    localparam logic [7:0] VERSION_OUT  = 8'd2;
    localparam logic [7:0] TEXT_MAX_LEN = 8'(MAX_TEXT_BYTES);

    // Record length limits, as the offset of the last byte.
    localparam logic [POS_W-1:0] LAST_POS_MIN = 7'(HEADER_BYTES);
    localparam logic [POS_W-1:0] LAST_POS_MAX = 7'(HEADER_BYTES + MAX_TEXT_BYTES - 1);

    localparam logic [20:0] CP_MAX       = 21'h10FFFF;
    localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;
    localparam logic [20:0] CP_MIN_2B    = 21'h000080;
    localparam logic [20:0] CP_MIN_3B    = 21'h000800;
    localparam logic [20:0] CP_MIN_4B    = 21'h010000;

    // Smallest legal code point of the sequence being assembled.
    typedef enum logic [1:0] {
        MIN_NONE  = 2'd0,
        MIN_80    = 2'd1,
        MIN_800   = 2'd2,
        MIN_10000 = 2'd3
    } min_class_t;

    typedef struct packed {
        logic [1:0]  cont_left;
        logic [20:0] code_point;
        min_class_t  min_class;
    } utf8_state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_record;
        logic       record_ok;
    } out_item_t;

endpackage

// ===== rtl/record_header_utf8_checker.sv =====
// Record header and UTF-8 checker, top level. Uses rhu8_pkg and rhu8_text_dec.
//
// One record byte per item goes in, one item per byte comes out, one item per
// clock while results are taken. An input register holds the byte, the
// header checks and one UTF-8 decoder step run between it and the result
// register, and the record state is updated as the byte moves on. Each byte is
// passed through unchanged except offset 1, which always leaves as 2. The item
// that carries the last byte has end_of_record set and record_ok telling
// whether the record was valid: length 57..120, magic 0,1,0,0 at bytes 0..3,
// nonzero id field (4..19) and hash field (20..51), zero pad (52..54), byte 55
// equal to the text length (1..64), and a strict UTF-8 text (no NUL, no
// overlong form, no surrogate, nothing above U+10FFFF, no cut-off sequence).
// The state clears after the last byte, so the next byte opens a new record.
// The byte counter saturates at 127; longer records just report invalid.
// While a result waits at the output, the input register still takes one item;
// after that the input stalls until the waiting result is taken.
module record_header_utf8_checker
    import rhu8_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    // pipeline registers
    logic        in_valid_reg;
    in_item_t    in_data_reg;
    logic        out_valid_reg;
    out_item_t   out_data_reg;
    out_item_t   out_data_next;

    // record state
    logic [POS_W-1:0] pos_reg,      pos_next;
    logic             failed_reg,   failed_next;
    logic             id_nz_reg,    id_nz_next;
    logic             hash_nz_reg,  hash_nz_next;
    logic [7:0]       decl_len_reg, decl_len_next;
    utf8_state_t      u8_reg,       u8_next;

    logic        advance;
    utf8_state_t dec_state;
    logic        dec_fail;
    logic [7:0]  b;
    logic        byte_nz;
    logic [7:0]  rec_len;
    logic [8:0]  exp_len;
    logic        len_ok;

    // item moves from input register to result register
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_item  = out_data_reg;

    assign b       = in_data_reg.data_byte;
    assign byte_nz = (b != 8'd0);

    rhu8_text_dec u_text_dec
    (
        .data_byte (b),
        .cur       (u8_reg),
        .nxt       (dec_state),
        .fail      (dec_fail)
    );

    // length of the record if this byte is its last
    assign rec_len = {1'b0, pos_reg} + 8'd1;
    assign exp_len = 9'(HEADER_BYTES) + {1'b0, decl_len_reg};
    assign len_ok  = (pos_reg >= LAST_POS_MIN) && (pos_reg <= LAST_POS_MAX) &&
                     ({1'b0, rec_len} == exp_len);

    always_comb
    begin
        failed_next   = failed_reg;
        id_nz_next    = id_nz_reg;
        hash_nz_next  = hash_nz_reg;
        decl_len_next = decl_len_reg;
        u8_next       = u8_reg;
        pos_next      = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 7'd1;

        if (pos_reg == POS_VERSION)
        begin
            if (b != VERSION_IN)
                failed_next = 1'b1;
        end
        else if (pos_reg <= POS_MAGIC3)
        begin
            if (byte_nz)
                failed_next = 1'b1;
        end
        else if (pos_reg <= ID_LAST)
        begin
            if (byte_nz)
                id_nz_next = 1'b1;
        end
        else if (pos_reg <= HASH_LAST)
        begin
            if (byte_nz)
                hash_nz_next = 1'b1;
        end
        else if (pos_reg <= PAD_LAST)
        begin
            if (byte_nz)
                failed_next = 1'b1;
        end
        else if (pos_reg == POS_LEN)
        begin
            decl_len_next = b;
            if (!byte_nz || b > TEXT_MAX_LEN)
                failed_next = 1'b1;
        end
        else if (!failed_reg)
        begin
            // text: decoding stops after the first failure
            if (dec_fail)
                failed_next = 1'b1;
            else
                u8_next = dec_state;
        end

        out_data_next.out_byte      = (pos_reg == POS_VERSION) ? VERSION_OUT : b;
        out_data_next.end_of_record = in_data_reg.last_byte;
        out_data_next.record_ok     = in_data_reg.last_byte && !failed_next &&
                                      id_nz_next && hash_nz_next &&
                                      (u8_next.cont_left == 2'd0) && len_ok;

        if (in_data_reg.last_byte)
        begin
            pos_next      = '0;
            failed_next   = 1'b0;
            id_nz_next    = 1'b0;
            hash_nz_next  = 1'b0;
            decl_len_next = 8'd0;
            u8_next       = '{cont_left: 2'd0, code_point: 21'd0, min_class: MIN_NONE};
        end
    end

    // control and record state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            failed_reg    <= 1'b0;
            id_nz_reg     <= 1'b0;
            hash_nz_reg   <= 1'b0;
            decl_len_reg  <= 8'd0;
            u8_reg        <= '{cont_left: 2'd0, code_point: 21'd0, min_class: MIN_NONE};
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                pos_reg      <= pos_next;
                failed_reg   <= failed_next;
                id_nz_reg    <= id_nz_next;
                hash_nz_reg  <= hash_nz_next;
                decl_len_reg <= decl_len_next;
                u8_reg       <= u8_next;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_data_reg <= in_item;
        if (advance)
            out_data_reg <= out_data_next;
    end

endmodule

// ===== rtl/rhu8_text_dec.sv =====
// One step of the strict UTF-8 decoder: takes a text byte and the decoder state.
// Depends on rhu8_pkg.
module rhu8_text_dec
    import rhu8_pkg::*;
(
    input  logic [7:0]  data_byte,
    input  utf8_state_t cur,
    output utf8_state_t nxt,
    output logic        fail
);

    logic [20:0] cp_shift;
    logic [20:0] lowest;

    assign cp_shift = {cur.code_point[14:0], data_byte[5:0]};

    always_comb
    begin
        unique case (cur.min_class)
            MIN_NONE,
            MIN_80:    lowest = CP_MIN_2B;
            MIN_800:   lowest = CP_MIN_3B;
            MIN_10000: lowest = CP_MIN_4B;
            default:   lowest = CP_MIN_4B;
        endcase
    end

    always_comb
    begin
        nxt  = cur;
        fail = 1'b0;
        if (cur.cont_left != 2'd0)
        begin
            if (data_byte[7:6] != 2'b10)
            begin
                fail = 1'b1;
            end
            else
            begin
                nxt.code_point = cp_shift;
                nxt.cont_left  = cur.cont_left - 2'd1;
                // sequence complete: range, overlong and surrogate checks
                if (cur.cont_left == 2'd1)
                begin
                    if (cp_shift < lowest || cp_shift > CP_MAX ||
                        (cp_shift >= CP_SURR_LO && cp_shift <= CP_SURR_HI))
                    begin
                        fail = 1'b1;
                    end
                end
            end
        end
        else
        begin
            case (data_byte) inside
                8'h00:
                begin
                    fail = 1'b1;
                end
                [8'h01:8'h7F]:
                begin
                end
                [8'hC2:8'hDF]:
                begin
                    nxt.code_point = {16'd0, data_byte[4:0]};
                    nxt.cont_left  = 2'd1;
                    nxt.min_class  = MIN_80;
                end
                [8'hE0:8'hEF]:
                begin
                    nxt.code_point = {17'd0, data_byte[3:0]};
                    nxt.cont_left  = 2'd2;
                    nxt.min_class  = MIN_800;
                end
                [8'hF0:8'hF4]:
                begin
                    nxt.code_point = {18'd0, data_byte[2:0]};
                    nxt.cont_left  = 2'd3;
                    nxt.min_class  = MIN_10000;
                end
                default:
                begin
                    fail = 1'b1;
                end
            endcase
        end
    end

endmodule

// ===== rtl/rhu8_checker.sv =====
// Port-level assertions for record_header_utf8_checker, bound to the top level.
// Depends on rhu8_pkg and record_header_utf8_checker_macros.svh.
`include "record_header_utf8_checker_macros.svh"

module rhu8_checker
    import rhu8_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);

    logic [POS_W-1:0] opos_reg;
    logic             out_acc;

    assign out_acc = out_valid && out_ready;

    // offset of the byte on the output within its record
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            opos_reg <= '0;
        else if (out_acc)
            opos_reg <= out_item.end_of_record ? '0 :
                        (opos_reg == POS_MAX) ? opos_reg : opos_reg + 7'd1;
    end

    `RHU8_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "output item changed while stalled")
    `RHU8_ASSERT_IMP(a_ok_on_last, out_valid && out_item.record_ok, out_item.end_of_record, "record_ok set on a byte that is not the last")
    `RHU8_ASSERT_IMP(a_version_out, out_valid && opos_reg == POS_VERSION, out_item.out_byte == VERSION_OUT, "version byte not rewritten")
    `RHU8_ASSERT_IMP(a_ok_length, out_valid && out_item.record_ok, opos_reg >= LAST_POS_MIN && opos_reg <= LAST_POS_MAX, "valid record with illegal length")

endmodule

bind record_header_utf8_checker rhu8_checker u_rhu8_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

// ===== dv/record_stream_checker.sv =====
// Checker for the record header / UTF-8 checker: predicts every result item
// from the accepted input items and compares. Depends on rhu8_pkg.
module record_stream_checker
    import rhu8_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_item,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_item,
    output int        mismatch_count,
    output int        expected_left
);

    localparam logic [7:0] LEAD2_LO  = 8'hC2;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF4;
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam int REPORT_LIMIT = 10;

    logic [POS_W-1:0] rec_pos;
    logic             rec_failed;
    logic             id_nonzero;
    logic             hash_nonzero;
    logic [7:0]       decl_len;
    utf8_state_t      dec;
    out_item_t        expected_items[$];

    function automatic void clear_record_state();
        rec_pos       = '0;
        rec_failed    = 1'b0;
        id_nonzero    = 1'b0;
        hash_nonzero  = 1'b0;
        decl_len      = '0;
        dec.cont_left = '0;
        dec.code_point = '0;
        dec.min_class = MIN_NONE;
    endfunction

    // Result for one record byte; advances the record state.
    function automatic out_item_t predict_out_item(in_item_t item);
        out_item_t        res;
        logic [7:0]       b;
        logic [POS_W-1:0] p;
        logic [20:0]      lowest;
        b = item.data_byte;
        p = rec_pos;
        res.out_byte      = (p == POS_VERSION) ? VERSION_OUT : b;
        res.end_of_record = item.last_byte;
        res.record_ok     = 1'b0;

        if (p < ID_FIRST)
        begin
            // magic 0,1,0,0
            if (b != ((p == POS_VERSION) ? VERSION_IN : 8'd0))
                rec_failed = 1'b1;
        end
        else if (p <= ID_LAST)
        begin
            if (b != 8'd0)
                id_nonzero = 1'b1;
        end
        else if (p <= HASH_LAST)
        begin
            if (b != 8'd0)
                hash_nonzero = 1'b1;
        end
        else if (p <= PAD_LAST)
        begin
            if (b != 8'd0)
                rec_failed = 1'b1;
        end
        else if (p == POS_LEN)
        begin
            decl_len = b;
            if (b == 8'd0 || b > TEXT_MAX_LEN)
                rec_failed = 1'b1;
        end
        else if (!rec_failed)
        begin
            if (dec.cont_left != 2'd0)
            begin
                if ((b & CONT_MASK) != CONT_TAG)
                    rec_failed = 1'b1;
                else
                begin
                    dec.code_point = {dec.code_point[14:0], b[5:0]};
                    dec.cont_left  = dec.cont_left - 2'd1;
                    if (dec.cont_left == 2'd0)
                    begin
                        lowest = (dec.min_class == MIN_80)  ? CP_MIN_2B :
                                 (dec.min_class == MIN_800) ? CP_MIN_3B : CP_MIN_4B;
                        if (dec.code_point < lowest || dec.code_point > CP_MAX ||
                            (dec.code_point >= CP_SURR_LO && dec.code_point <= CP_SURR_HI))
                            rec_failed = 1'b1;
                    end
                end
            end
            else if (b == 8'd0)
                rec_failed = 1'b1;
            else if (b[7])
            begin
                if (b >= LEAD2_LO && b <= LEAD2_HI)
                begin
                    dec.code_point = {16'd0, b[4:0]};
                    dec.cont_left  = 2'd1;
                    dec.min_class  = MIN_80;
                end
                else if (b >= LEAD3_LO && b <= LEAD3_HI)
                begin
                    dec.code_point = {17'd0, b[3:0]};
                    dec.cont_left  = 2'd2;
                    dec.min_class  = MIN_800;
                end
                else if (b >= LEAD4_LO && b <= LEAD4_HI)
                begin
                    dec.code_point = {18'd0, b[2:0]};
                    dec.cont_left  = 2'd3;
                    dec.min_class  = MIN_10000;
                end
                else
                    rec_failed = 1'b1;
            end
        end

        if (rec_pos != POS_MAX)
            rec_pos = rec_pos + 7'd1;

        if (item.last_byte)
        begin
            res.record_ok = !rec_failed && id_nonzero && hash_nonzero &&
                            dec.cont_left == 2'd0 &&
                            p >= LAST_POS_MIN && p <= LAST_POS_MAX &&
                            int'(p) + 1 == HEADER_BYTES + int'(decl_len);
            clear_record_state();
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        logic      bad;
        if (!rst_n)
        begin
            clear_record_state();
            expected_items.delete();
            expected_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_items.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: result item with none expected: byte %h eor %b ok %b",
                                 $realtime, out_item.out_byte, out_item.end_of_record,
                                 out_item.record_ok);
                end
                else
                begin
                    want = expected_items.pop_front();
                    bad  = (out_item.out_byte !== want.out_byte) ||
                           (out_item.end_of_record !== want.end_of_record) ||
                           (out_item.record_ok !== want.record_ok);
                    if (bad)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("%0t: exp byte %h eor %b ok %b, got byte %h eor %b ok %b",
                                     $realtime, want.out_byte, want.end_of_record,
                                     want.record_ok, out_item.out_byte,
                                     out_item.end_of_record, out_item.record_ok);
                    end
                end
            end
            if (in_valid && in_ready)
                expected_items.push_back(predict_out_item(in_item));
            expected_left = expected_items.size();
        end
    end

endmodule

// ===== dv/tb_record_header_utf8_checker.sv =====
// Top of the record header / UTF-8 checker testbench: clock, reset, record
// stimulus, output back-pressure and the verdict.
// Depends on rhu8_pkg, record_stream_checker and the block under test.
module tb_record_header_utf8_checker
    import rhu8_pkg::*;
();

    // Long output hold-off, so the block fills and stalls its input.
    localparam int LONG_HOLD    = 300;
    // Result count at which the receiver starts the long hold-off.
    localparam int LONG_HOLD_AT = 150;
    // Cycles without any accepted item before the run is declared hung.
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_RECS  = 2;
    localparam int DRAIN_CYCLES = 10;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    int mismatch_count;
    int expected_left;
    int idle_cycles;

    // Record under construction, one entry per byte.
    logic [7:0] rec_bytes[$];

    logic tx_burst;            // sender: no gaps for the current record
    logic rx_burst;            // receiver: no gaps for the current stretch

    always #5 clk = ~clk;

    record_header_utf8_checker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    record_stream_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_item       (out_item),
        .mismatch_count (mismatch_count),
        .expected_left  (expected_left)
    );

    // ------------------------------------------------------------------
    // Record building
    // ------------------------------------------------------------------

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    // Push the low n bytes of word, most significant first.
    task automatic push_seq(input int n, input logic [31:0] word);
        for (int i = n - 1; i >= 0; i--)
            rec_bytes.push_back(word[8*i +: 8]);
    endtask

    // Valid header: magic 0,1,0,0, sparse random id and hash with at least
    // one nonzero byte each, zero pad, declared text length.
    task automatic begin_record(input logic [7:0] decl);
        rec_bytes.delete();
        push_seq(4, 32'h00010000);
        for (int i = 0; i < 48; i++)
            rec_bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'd0);
        rec_bytes[$urandom_range(ID_FIRST, ID_LAST)]     = 8'($urandom_range(1, 255));
        rec_bytes[$urandom_range(HASH_FIRST, HASH_LAST)] = 8'($urandom_range(1, 255));
        push_seq(4, {24'd0, decl});
    endtask

    // One well-formed UTF-8 character of n bytes, edges of each range included.
    task automatic add_char(input int n);
        logic [7:0] lead;
        case (n)
            1: rec_bytes.push_back(8'($urandom_range(1, 127)));
            2:
            begin
                rec_bytes.push_back(8'($urandom_range(8'hC2, 8'hDF)));
                rec_bytes.push_back(cont_byte());
            end
            3:
            begin
                lead = 8'($urandom_range(8'hE0, 8'hEF));
                rec_bytes.push_back(lead);
                if (lead == 8'hE0)          // no overlong forms
                    rec_bytes.push_back(8'($urandom_range(8'hA0, 8'hBF)));
                else if (lead == 8'hED)     // no surrogates
                    rec_bytes.push_back(8'($urandom_range(8'h80, 8'h9F)));
                else
                    rec_bytes.push_back(cont_byte());
                rec_bytes.push_back(cont_byte());
            end
            default:
            begin
                lead = 8'($urandom_range(8'hF0, 8'hF4));
                rec_bytes.push_back(lead);
                if (lead == 8'hF0)
                    rec_bytes.push_back(8'($urandom_range(8'h90, 8'hBF)));
                else if (lead == 8'hF4)     // stay at or below U+10FFFF
                    rec_bytes.push_back(8'($urandom_range(8'h80, 8'h8F)));
                else
                    rec_bytes.push_back(cont_byte());
                rec_bytes.push_back(cont_byte());
                rec_bytes.push_back(cont_byte());
            end
        endcase
    endtask

    // Exactly n bytes of well-formed text.
    task automatic fill_text(input int n);
        int left;
        int k;
        left = n;
        while (left > 0)
        begin
            k = $urandom_range(1, (left < 4) ? left : 4);
            add_char(k);
            left -= k;
        end
    endtask

    // One ill-formed piece of text.
    task automatic push_bad_seq();
        case ($urandom_range(0, 7))
            0: rec_bytes.push_back(8'd0);
            1: rec_bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'hC0, 8'hC1))
                                                         : 8'($urandom_range(8'hF5, 8'hFF)));
            2: rec_bytes.push_back(cont_byte());
            3:
            begin
                rec_bytes.push_back(8'hE0);
                rec_bytes.push_back(8'($urandom_range(8'h80, 8'h9F)));
                rec_bytes.push_back(cont_byte());
            end
            4:
            begin
                rec_bytes.push_back(8'hED);
                rec_bytes.push_back(8'($urandom_range(8'hA0, 8'hBF)));
                rec_bytes.push_back(cont_byte());
            end
            5:
            begin
                rec_bytes.push_back(8'hF0);
                rec_bytes.push_back(8'($urandom_range(8'h80, 8'h8F)));
                rec_bytes.push_back(cont_byte());
                rec_bytes.push_back(cont_byte());
            end
            6:
            begin
                rec_bytes.push_back(8'hF4);
                rec_bytes.push_back(8'($urandom_range(8'h90, 8'hBF)));
                rec_bytes.push_back(cont_byte());
                rec_bytes.push_back(cont_byte());
            end
            default:
            begin
                // lead byte followed by something that is not a continuation
                rec_bytes.push_back(8'($urandom_range(8'hC2, 8'hDF)));
                rec_bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 127))
                                                         : 8'($urandom_range(8'hC0, 8'hFF)));
            end
        endcase
    endtask

    // Half of the records are well-formed with random content; the rest break one rule.
    task automatic build_random_record();
        int kind;
        int tlen;
        int n;
        kind = $urandom_range(0, 15);
        tlen = ($urandom_range(0, 4) == 0) ? $urandom_range(1, MAX_TEXT_BYTES)
                                           : $urandom_range(1, 12);
        begin_record(8'(tlen));
        case (kind)
            8:
            begin
                fill_text(tlen);
                rec_bytes[$urandom_range(0, POS_MAGIC3)] = 8'($urandom_range(0, 255));
            end
            9:
            begin
                fill_text(tlen);
                if ($urandom_range(0, 1))
                    for (int i = ID_FIRST; i <= ID_LAST; i++) rec_bytes[i] = 8'd0;
                else
                    for (int i = HASH_FIRST; i <= HASH_LAST; i++) rec_bytes[i] = 8'd0;
            end
            10:
            begin
                fill_text(tlen);
                rec_bytes[$urandom_range(PAD_FIRST, PAD_LAST)] = 8'($urandom_range(1, 255));
            end
            11:
            begin
                fill_text(tlen);
                case ($urandom_range(0, 2))
                    0: rec_bytes[POS_LEN] = 8'd0;
                    1: rec_bytes[POS_LEN] = 8'($urandom_range(MAX_TEXT_BYTES + 1, 255));
                    default: rec_bytes[POS_LEN] = 8'($urandom_range(1, MAX_TEXT_BYTES));
                endcase
            end
            12:
            begin
                fill_text($urandom_range(0, 4));
                push_bad_seq();
                fill_text($urandom_range(0, 4));
                rec_bytes[POS_LEN] = 8'(rec_bytes.size() - HEADER_BYTES);
            end
            13:
            begin
                // record ends inside a multi-byte character
                fill_text($urandom_range(0, 4));
                n = $urandom_range(2, 4);
                add_char(n);
                repeat ($urandom_range(1, n - 1)) void'(rec_bytes.pop_back());
                rec_bytes[POS_LEN] = 8'(rec_bytes.size() - HEADER_BYTES);
            end
            14:
            begin
                // too long; past 127 bytes the position counter saturates
                fill_text($urandom_range(MAX_TEXT_BYTES + 1, MAX_TEXT_BYTES + 20));
                rec_bytes[POS_LEN] = 8'($urandom_range(1, 255));
            end
            15:
            begin
                if ($urandom_range(0, 1))
                begin
                    n = $urandom_range(1, HEADER_BYTES);
                    while (rec_bytes.size() > n) void'(rec_bytes.pop_back());
                end
                else
                begin
                    rec_bytes.delete();
                    repeat ($urandom_range(1, 80))
                        rec_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end
            default: fill_text(tlen);
        endcase
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Sends rec_bytes, last marker on the final byte. Valid is left high
    // after the final item so that a following record can go back to back;
    // every caller that stops sending lowers it through drain_results.
    task automatic send_record();
        in_item_t nxt;
        int       gap;
        tx_burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < rec_bytes.size(); i++)
        begin
            gap = tx_burst ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            nxt.data_byte = rec_bytes[i];
            nxt.last_byte = (i == rec_bytes.size() - 1);
            in_valid <= 1'b1;
            in_item  <= nxt;
            do @(posedge clk); while (!in_ready);
            @(negedge clk);
        end
    endtask

    // Stop offering items until every expected result has come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        wait (expected_left == 0);
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        tx_burst = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // --- directed records ---
        // shortest valid record
        begin_record(8'd1); rec_bytes.push_back(8'h01); send_record();
        // both ends of ASCII and edges of every multi-byte class
        begin_record(8'd23);
        push_seq(2, 32'h017F);
        push_seq(2, 32'hC280);     push_seq(2, 32'hDFBF);
        push_seq(3, 32'hE0A080);   push_seq(3, 32'hED9FBF);   push_seq(3, 32'hEFBFBF);
        push_seq(4, 32'hF0908080); push_seq(4, 32'hF48FBFBF);
        send_record();
        // longest valid record; the long receiver hold-off falls here
        begin_record(8'(MAX_TEXT_BYTES)); fill_text(MAX_TEXT_BYTES); send_record();
        // surrogate, truncated sequence at the last byte
        begin_record(8'd3); push_seq(3, 32'hEDA080); send_record();
        begin_record(8'd2); push_seq(2, 32'hE0A0);   send_record();
        // long enough to saturate the position counter
        begin_record(8'd73); fill_text(73); send_record();
        // short record whose version byte is not 1, still rewritten to 2
        begin_record(8'd0);
        while (rec_bytes.size() > 30) void'(rec_bytes.pop_back());
        rec_bytes[POS_VERSION] = 8'hFF;
        send_record();
        // one-byte record
        rec_bytes.delete(); rec_bytes.push_back(8'h00); send_record();
        drain_results();

        // --- random records ---
        for (int r = 0; r < RANDOM_RECS; r++)
        begin
            if ($urandom_range(0, 5) == 0)
                drain_results();
            build_random_record();
            send_record();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side: random gaps, burst stretches, one long hold-off
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int wait_cycles;
        int taken;
        out_ready = 1'b0;
        rx_burst  = 1'b0;
        taken     = 0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (taken % 50 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            wait_cycles = rx_burst ? 0 : $urandom_range(0, 6);
            // sender keeps offering items while the output is held
            if (taken == LONG_HOLD_AT)
                wait_cycles += LONG_HOLD;
            if (wait_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
            @(negedge clk);
        end
    end

    // Hang detection: any accepted item on either side restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
